[sv/assert_macros.svh]
// assertion helpers for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/rgbfade_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbfade_pkg
// types and constants of the rgb cross-fade led framer
// ----------------------------------------------------------------------------
package rgbfade_pkg;

    localparam int BYTE_W = 8;
    localparam int STEP_W = 8;
    localparam int ACC_W  = 16;
    localparam int BRT_W  = 5;
    localparam int IDX_W  = 4;
    localparam int CFG_W  = 3;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [STEP_W-1:0] step_t;
    typedef logic [ACC_W-1:0]  acc_t;
    typedef logic [BRT_W-1:0]  brt_t;
    typedef logic [IDX_W-1:0]  byte_idx_t;

    typedef enum logic [CFG_W-1:0] {
        REG_START_RED         = 3'd0,
        REG_START_GREEN       = 3'd1,
        REG_START_BLUE        = 3'd2,
        REG_END_RED           = 3'd3,
        REG_END_GREEN         = 3'd4,
        REG_END_BLUE          = 3'd5,
        REG_GLOBAL_BRIGHTNESS = 3'd6
    } cfg_reg_t;

    localparam byte_idx_t BYTE_FIRST = 4'd0;
    localparam byte_idx_t BYTE_HDR   = 4'd4;
    localparam byte_idx_t BYTE_BLUE  = 4'd5;
    localparam byte_idx_t BYTE_GREEN = 4'd6;
    localparam byte_idx_t BYTE_RED   = 4'd7;
    localparam byte_idx_t BYTE_LAST  = 4'd11;

    localparam byte_t START_FILL = 8'h00;
    localparam byte_t END_FILL   = 8'hFF;
    localparam byte_t HDR_MARK   = 8'hE0;

    localparam byte_t RST_START_RED   = 8'd255;
    localparam byte_t RST_START_GREEN = 8'd0;
    localparam byte_t RST_START_BLUE  = 8'd255;
    localparam byte_t RST_END_RED     = 8'd0;
    localparam byte_t RST_END_GREEN   = 8'd255;
    localparam byte_t RST_END_BLUE    = 8'd0;
    localparam brt_t  RST_BRIGHTNESS  = 5'd7;

endpackage

[sv/rgb_pingpong_fade_led_framer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_pingpong_fade_led_framer_unit: linear rgb cross-fade led frame source
// first frame byte is registered and valid in the cycle after a tick word is accepted
// one frame byte per cycle from the output register unless out_stall; twelve per tick
// reset: color registers to defaults, fade step zero fading up, output empty
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_pingpong_fade_led_framer_unit #(
    parameter int FADE_STEPS = 50
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            frame_tick,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [rgbfade_pkg::BYTE_W-1:0]  frame_byte,
    output logic                            last_byte,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rgbfade_pkg::CFG_W-1:0]   cfg_index,
    input  logic [rgbfade_pkg::BYTE_W-1:0]  cfg_data
);

    localparam rgbfade_pkg::step_t STEPS_U = rgbfade_pkg::STEP_W'(FADE_STEPS);
    localparam int DIV_SHIFT = rgbfade_pkg::ACC_W + $clog2(FADE_STEPS);
    localparam int RECIP_W   = rgbfade_pkg::ACC_W + 2;
    localparam int PROD_W    = rgbfade_pkg::ACC_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((2 ** DIV_SHIFT) + FADE_STEPS - 1) / FADE_STEPS);

    // configuration
    rgbfade_pkg::byte_t start_red_reg, start_green_reg, start_blue_reg;
    rgbfade_pkg::byte_t end_red_reg, end_green_reg, end_blue_reg;
    rgbfade_pkg::brt_t  brightness_reg;

    // fade state
    rgbfade_pkg::step_t step_reg, step_next;
    logic               down_reg, down_next;
    rgbfade_pkg::step_t pos_reg;

    // blend pipeline
    rgbfade_pkg::acc_t  acc_blue_reg, acc_green_reg, acc_red_reg;
    logic [PROD_W-1:0]  prod_blue_reg, prod_green_reg, prod_red_reg;
    rgbfade_pkg::byte_t blue_q, green_q, red_q;
    rgbfade_pkg::acc_t  pos_w, rem_w;

    // output side
    logic                   out_valid_reg, out_valid_next;
    rgbfade_pkg::byte_idx_t cnt_reg, cnt_next;
    rgbfade_pkg::byte_t     frame_byte_reg, frame_byte_next;
    rgbfade_pkg::byte_idx_t load_idx;
    logic                   load_byte;

    logic in_accept, tick_go, out_take, frame_end;
    logic [rgbfade_pkg::STEP_W:0] step_inc;

    assign cfg_ready = 1'b1;

    assign out_take  = out_valid_reg && !out_stall;
    assign frame_end = out_take && (cnt_reg == rgbfade_pkg::BYTE_LAST);
    assign in_stall  = out_valid_reg && !frame_end;
    assign in_accept = in_valid && !in_stall;
    assign tick_go   = in_accept && frame_tick;

    // fade step sequencing
    assign step_inc = {1'b0, step_reg} + 1'b1;

    always_comb
    begin
        step_next = step_reg;
        down_next = down_reg;
        if (tick_go)
        begin
            if (!down_reg)
            begin
                if (step_inc >= {1'b0, STEPS_U})
                begin
                    step_next = STEPS_U;
                    down_next = 1'b1;
                end
                else
                begin
                    step_next = step_inc[rgbfade_pkg::STEP_W-1:0];
                end
            end
            else
            begin
                if (step_reg > rgbfade_pkg::step_t'(1))
                begin
                    step_next = step_reg - 1'b1;
                end
                else
                begin
                    step_next = '0;
                    down_next = 1'b0;
                end
            end
        end
    end

    // blend: floor((from*(n-pos) + to*pos) / n) by reciprocal multiply
    assign pos_w = rgbfade_pkg::ACC_W'(pos_reg);
    assign rem_w = rgbfade_pkg::ACC_W'(STEPS_U - pos_reg);

    assign blue_q  = prod_blue_reg[DIV_SHIFT +: rgbfade_pkg::BYTE_W];
    assign green_q = prod_green_reg[DIV_SHIFT +: rgbfade_pkg::BYTE_W];
    assign red_q   = prod_red_reg[DIV_SHIFT +: rgbfade_pkg::BYTE_W];

    always_ff @(posedge clk)
    begin
        acc_blue_reg   <= rgbfade_pkg::ACC_W'(start_blue_reg) * rem_w
                        + rgbfade_pkg::ACC_W'(end_blue_reg) * pos_w;
        acc_green_reg  <= rgbfade_pkg::ACC_W'(start_green_reg) * rem_w
                        + rgbfade_pkg::ACC_W'(end_green_reg) * pos_w;
        acc_red_reg    <= rgbfade_pkg::ACC_W'(start_red_reg) * rem_w
                        + rgbfade_pkg::ACC_W'(end_red_reg) * pos_w;
        prod_blue_reg  <= PROD_W'(acc_blue_reg) * PROD_W'(RECIP);
        prod_green_reg <= PROD_W'(acc_green_reg) * PROD_W'(RECIP);
        prod_red_reg   <= PROD_W'(acc_red_reg) * PROD_W'(RECIP);
    end

    // frame byte sequencing
    always_comb
    begin
        out_valid_next = out_valid_reg;
        cnt_next       = cnt_reg;
        load_byte      = 1'b0;
        load_idx       = rgbfade_pkg::BYTE_FIRST;
        if (tick_go)
        begin
            out_valid_next = 1'b1;
            cnt_next       = rgbfade_pkg::BYTE_FIRST;
            load_byte      = 1'b1;
        end
        else if (out_take)
        begin
            if (cnt_reg == rgbfade_pkg::BYTE_LAST)
            begin
                out_valid_next = 1'b0;
            end
            else
            begin
                cnt_next  = cnt_reg + 1'b1;
                load_byte = 1'b1;
                load_idx  = cnt_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        if (load_idx < rgbfade_pkg::BYTE_HDR)
        begin
            frame_byte_next = rgbfade_pkg::START_FILL;
        end
        else if (load_idx > rgbfade_pkg::BYTE_RED)
        begin
            frame_byte_next = rgbfade_pkg::END_FILL;
        end
        else
        begin
            case (load_idx)
                rgbfade_pkg::BYTE_HDR:
                    frame_byte_next = rgbfade_pkg::HDR_MARK
                                    | rgbfade_pkg::BYTE_W'(brightness_reg);
                rgbfade_pkg::BYTE_BLUE:  frame_byte_next = blue_q;
                rgbfade_pkg::BYTE_GREEN: frame_byte_next = green_q;
                rgbfade_pkg::BYTE_RED:   frame_byte_next = red_q;
                default:                 frame_byte_next = rgbfade_pkg::START_FILL;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_byte)
        begin
            frame_byte_reg <= frame_byte_next;
        end
        if (tick_go)
        begin
            pos_reg <= step_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            cnt_reg         <= rgbfade_pkg::BYTE_FIRST;
            step_reg        <= '0;
            down_reg        <= 1'b0;
            start_red_reg   <= rgbfade_pkg::RST_START_RED;
            start_green_reg <= rgbfade_pkg::RST_START_GREEN;
            start_blue_reg  <= rgbfade_pkg::RST_START_BLUE;
            end_red_reg     <= rgbfade_pkg::RST_END_RED;
            end_green_reg   <= rgbfade_pkg::RST_END_GREEN;
            end_blue_reg    <= rgbfade_pkg::RST_END_BLUE;
            brightness_reg  <= rgbfade_pkg::RST_BRIGHTNESS;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            step_reg      <= step_next;
            down_reg      <= down_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rgbfade_pkg::REG_START_RED:   start_red_reg   <= cfg_data;
                    rgbfade_pkg::REG_START_GREEN: start_green_reg <= cfg_data;
                    rgbfade_pkg::REG_START_BLUE:  start_blue_reg  <= cfg_data;
                    rgbfade_pkg::REG_END_RED:     end_red_reg     <= cfg_data;
                    rgbfade_pkg::REG_END_GREEN:   end_green_reg   <= cfg_data;
                    rgbfade_pkg::REG_END_BLUE:    end_blue_reg    <= cfg_data;
                    rgbfade_pkg::REG_GLOBAL_BRIGHTNESS:
                        brightness_reg <= cfg_data[rgbfade_pkg::BRT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = frame_byte_reg;
    assign last_byte  = (cnt_reg == rgbfade_pkg::BYTE_LAST);

    // checks
    `ASSERT_NEXT(a_frame_starts, tick_go, out_valid && cnt_reg == rgbfade_pkg::BYTE_FIRST && frame_byte == rgbfade_pkg::START_FILL, "frame did not start with a fill word")
    `ASSERT_NEXT(a_no_gap, out_take && !last_byte, out_valid, "frame word stream broke mid frame")
    `ASSERT_IMPLIES(a_down_range, down_reg, step_reg != '0 && step_reg <= STEPS_U, "fade step out of range fading down")
    `ASSERT_IMPLIES(a_up_range, !down_reg, step_reg < STEPS_U, "fade step out of range fading up")

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the rgb ping-pong cross-fade led framer
// Drives frame ticks and register writes and keeps a model of the fade step,
// its direction and the color registers. Every tick that gets in queues the
// twelve frame bytes it should produce. Each byte that leaves the block is
// compared with the oldest one queued. The run has directed tests and then
// random ticks under several patterns of input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int FADE_STEPS   = 50;
    localparam int FRAME_BYTES  = 12;
    localparam int HOLD_CYCLES  = 240;
    localparam int DRAIN_CYCLES = 16;
    localparam int TICKS_PER_PHASE = 66;
    localparam int CYCLE_LIMIT  = 300000;

    localparam logic [rgbfade_pkg::CFG_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        rgbfade_pkg::byte_t data;
        logic  last;
    } frame_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_stall;
    logic frame_tick = 1'b0;

    logic out_valid;
    logic out_stall = 1'b0;
    rgbfade_pkg::byte_t frame_byte;
    logic last_byte;

    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [rgbfade_pkg::CFG_W-1:0] cfg_index = '0;
    rgbfade_pkg::byte_t cfg_data = '0;

    // model of the block
    rgbfade_pkg::byte_t from_red, from_green, from_blue;
    rgbfade_pkg::byte_t to_red, to_green, to_blue;
    rgbfade_pkg::brt_t brightness;
    rgbfade_pkg::step_t fade_pos;
    logic fading_down;

    frame_word_t frame_bytes_due[$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    int errors = 0;
    int cycles = 0;
    int ticks_sent = 0;
    int idle_words = 0;
    int bytes_checked = 0;
    int reg_writes = 0;

    rgb_pingpong_fade_led_framer_unit #(
        .FADE_STEPS(FADE_STEPS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .frame_tick (frame_tick),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .last_byte  (last_byte),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[rgb_pingpong_fade_led_framer_unit] ERROR");
            $finish;
        end
    end

    // receiver stall, with a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // outputs are stable by the falling edge, so sample there
    always @(negedge clk)
    begin
        frame_word_t exp_word;
        if (rst_n && out_valid && !out_stall)
        begin
            if (frame_bytes_due.size() == 0)
            begin
                $display("%0t: unexpected frame byte %02h last %0b",
                         $time, frame_byte, last_byte);
                errors++;
            end
            else
            begin
                exp_word = frame_bytes_due.pop_front();
                if (frame_byte !== exp_word.data)
                begin
                    $display("%0t: frame_byte expected %02h actual %02h",
                             $time, exp_word.data, frame_byte);
                    errors++;
                end
                if (last_byte !== exp_word.last)
                begin
                    $display("%0t: last_byte expected %0b actual %0b",
                             $time, exp_word.last, last_byte);
                    errors++;
                end
                bytes_checked++;
            end
        end
    end

    function automatic rgbfade_pkg::byte_t fade_mix(input rgbfade_pkg::byte_t a,
                                                    input rgbfade_pkg::byte_t b,
                                                    input int pos);
        int acc;
        acc = int'(a) * (FADE_STEPS - pos) + int'(b) * pos;
        return rgbfade_pkg::byte_t'(acc / FADE_STEPS);
    endfunction

    task automatic reset_colors();
        from_red = rgbfade_pkg::RST_START_RED;
        from_green = rgbfade_pkg::RST_START_GREEN;
        from_blue = rgbfade_pkg::RST_START_BLUE;
        to_red = rgbfade_pkg::RST_END_RED;
        to_green = rgbfade_pkg::RST_END_GREEN;
        to_blue = rgbfade_pkg::RST_END_BLUE;
        brightness = rgbfade_pkg::RST_BRIGHTNESS;
        fade_pos = '0;
        fading_down = 1'b0;
    endtask

    task automatic queue_frame(input logic tick);
        rgbfade_pkg::byte_t frame[FRAME_BYTES];
        int pos;
        if (!tick)
            return;
        pos = (fade_pos > FADE_STEPS) ? FADE_STEPS : int'(fade_pos);
        for (int k = 0; k < FRAME_BYTES; k++)
            frame[k] = (k < rgbfade_pkg::BYTE_HDR) ? rgbfade_pkg::START_FILL
                                                   : rgbfade_pkg::END_FILL;
        frame[rgbfade_pkg::BYTE_HDR] = rgbfade_pkg::HDR_MARK
                                     | rgbfade_pkg::byte_t'(brightness);
        frame[rgbfade_pkg::BYTE_BLUE] = fade_mix(from_blue, to_blue, pos);
        frame[rgbfade_pkg::BYTE_GREEN] = fade_mix(from_green, to_green, pos);
        frame[rgbfade_pkg::BYTE_RED] = fade_mix(from_red, to_red, pos);
        for (int k = 0; k < FRAME_BYTES; k++)
            frame_bytes_due.push_back('{data: frame[k],
                                        last: (k == rgbfade_pkg::BYTE_LAST)});
        if (!fading_down)
        begin
            fade_pos = fade_pos + 1'b1;
            if (fade_pos >= FADE_STEPS)
            begin
                fade_pos = rgbfade_pkg::step_t'(FADE_STEPS);
                fading_down = 1'b1;
            end
        end
        else if (fade_pos > 1)
        begin
            fade_pos = fade_pos - 1'b1;
        end
        else
        begin
            fade_pos = '0;
            fading_down = 1'b0;
        end
    endtask

    task automatic send_word(input logic tick);
        logic taken;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            frame_tick <= 1'($urandom);
            @(posedge clk);
        end
        in_valid <= 1'b1;
        frame_tick <= tick;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        queue_frame(tick);
        if (tick)
            ticks_sent++;
        else
            idle_words++;
    endtask

    task automatic write_reg(input logic [rgbfade_pkg::CFG_W-1:0] idx,
                             input rgbfade_pkg::byte_t data);
        logic taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        reg_writes++;
        case (idx)
            rgbfade_pkg::REG_START_RED:         from_red = data;
            rgbfade_pkg::REG_START_GREEN:       from_green = data;
            rgbfade_pkg::REG_START_BLUE:        from_blue = data;
            rgbfade_pkg::REG_END_RED:           to_red = data;
            rgbfade_pkg::REG_END_GREEN:         to_green = data;
            rgbfade_pkg::REG_END_BLUE:          to_blue = data;
            rgbfade_pkg::REG_GLOBAL_BRIGHTNESS: brightness = rgbfade_pkg::brt_t'(data);
            default: ;
        endcase
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        wait (frame_bytes_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_colors(input rgbfade_pkg::byte_t sr, input rgbfade_pkg::byte_t sg,
                              input rgbfade_pkg::byte_t sb, input rgbfade_pkg::byte_t er,
                              input rgbfade_pkg::byte_t eg, input rgbfade_pkg::byte_t eb,
                              input rgbfade_pkg::byte_t brt);
        drain();
        write_reg(rgbfade_pkg::REG_START_RED, sr);
        write_reg(rgbfade_pkg::REG_START_GREEN, sg);
        write_reg(rgbfade_pkg::REG_START_BLUE, sb);
        write_reg(rgbfade_pkg::REG_END_RED, er);
        write_reg(rgbfade_pkg::REG_END_GREEN, eg);
        write_reg(rgbfade_pkg::REG_END_BLUE, eb);
        write_reg(rgbfade_pkg::REG_GLOBAL_BRIGHTNESS, brt);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_colors();
        repeat (3) send_word(1'b1);
    endtask

    // low tick words must leave the step alone
    task automatic test_tick_low();
        send_word(1'b0);
        send_word(1'b1);
        send_word(1'b0);
        send_word(1'b0);
        send_word(1'b1);
    endtask

    task automatic test_register_extremes();
        set_colors(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00);
        repeat (2) send_word(1'b1);
        // brightness keeps only its low five bits
        set_colors(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_word(1'b1);
        set_colors(8'hFF, 8'h80, 8'h01, 8'h00, 8'h7F, 8'hFE, 8'hE0);
        send_word(1'b1);
        set_colors(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1F);
        send_word(1'b1);
    endtask

    task automatic test_unused_index();
        set_colors(8'h12, 8'h34, 8'h56, 8'hA9, 8'hCB, 8'hED, 8'h15);
        @(posedge clk);
        write_reg(REG_UNUSED, 8'hFF);
        write_reg(REG_UNUSED, 8'h00);
        cfg_valid <= 1'b0;
        repeat (2) send_word(1'b1);
    endtask

    task automatic test_output_hold();
        drain();
        send_idle_pct = 0;
        stall_pct = 0;
        @(negedge clk);
        hold_requests++;
        @(posedge clk);
        repeat (30) send_word(1'b1);
        drain();
    endtask

    task automatic test_random_fade();
        int send_pcts[4] = '{0, 47, 0, 26};
        int stall_pcts[4] = '{0, 0, 47, 26};
        int phase_ticks;
        logic tick;
        for (int ph = 0; ph < 4; ph++)
        begin
            if (ph == 1)
                set_colors(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h1F);
            else
                set_colors(8'($urandom), 8'($urandom), 8'($urandom),
                           8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            send_idle_pct = send_pcts[ph];
            stall_pct = stall_pcts[ph];
            phase_ticks = 0;
            while (phase_ticks < TICKS_PER_PHASE)
            begin
                tick = ($urandom_range(0, 99) < 85);
                send_word(tick);
                if (tick)
                    phase_ticks++;
            end
        end
        drain();
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        reset_colors();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_colors();
        test_tick_low();
        test_register_extremes();
        test_unused_index();
        test_output_hold();
        test_random_fade();

        drain();
        $display("run covered %0d ticks and %0d low tick words over four gap/stall mixes",
                 ticks_sent, idle_words);
        $display("%0d frame bytes checked, %0d register writes, %0d mismatches",
                 bytes_checked, reg_writes, errors);
        if (errors == 0)
            $display("[rgb_pingpong_fade_led_framer_unit] OK");
        else
            $display("[rgb_pingpong_fade_led_framer_unit] ERROR");
        $finish;
    end

endmodule
